// ----- hw/rtl/crdg_pkg.sv -----
// Shared types and constants for the camera ray direction generator.
`default_nettype none

package crdg_pkg;

   localparam int COMP_W    = 20;
   localparam int VEC_W     = 3 * COMP_W;
   localparam int PIX_W     = 12;
   localparam int JIT_W     = 16;
   localparam int DIR_W     = 16;
   localparam int NORM_BITS = 30;
   localparam int SQ_W      = 2 * NORM_BITS + 2;
   localparam int ROOT_W    = SQ_W / 2;
   localparam int NUM_W     = NORM_BITS + DIR_W + 1;
   localparam int DEN_W     = ROOT_W + 1;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CORNER_OFFSET = 2'd0,
      CSR_STEP_U        = 2'd1,
      CSR_STEP_V        = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } flags_type;

   typedef struct packed {
      logic [2:0][NORM_BITS-1:0] a;
      flags_type                 flags;
   } norm_side_type;

endpackage

`default_nettype wire

// ----- hw/rtl/crdg_ifaces.sv -----
// Handshake channel interfaces for sample requests, ray responses and register writes.
`default_nettype none

interface crdg_req_if;
   import crdg_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_x;
   logic [PIX_W-1:0] pixel_y;
   logic [JIT_W-1:0] jitter_u;
   logic [JIT_W-1:0] jitter_v;
   modport source (output valid, pixel_x, pixel_y, jitter_u, jitter_v, input ready);
   modport sink   (input valid, pixel_x, pixel_y, jitter_u, jitter_v, output ready);
endinterface

interface crdg_rsp_if;
   import crdg_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [DIR_W-1:0] dir_x;
   logic signed [DIR_W-1:0] dir_y;
   logic signed [DIR_W-1:0] dir_z;
   logic                    degenerate;
   modport source (output valid, dir_x, dir_y, dir_z, degenerate, input ready);
   modport sink   (input valid, dir_x, dir_y, dir_z, degenerate, output ready);
endinterface

interface crdg_csr_if;
   import crdg_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [VEC_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/crdg_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a sideband that travels alongside.
`default_nettype none

module crdg_isqrt
   import crdg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [SQ_W-1:0]   in_rad,
   input  wire norm_side_type     in_side,
   output logic                   out_valid,
   output logic [ROOT_W-1:0]      out_root,
   output norm_side_type          out_side
);

   localparam int NS    = ROOT_W;
   localparam int REM_W = ROOT_W + 3;

   logic [REM_W-1:0]  rem_ff  [NS];
   logic [ROOT_W-1:0] root_ff [NS];
   logic [SQ_W-1:0]   rad_ff  [NS];
   norm_side_type     side_ff [NS];
   logic [NS-1:0]     v_ff;

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic [REM_W-1:0]  rem_prev, rem_cat, trial, rem_in;
      logic [ROOT_W-1:0] root_prev, root_in;
      logic [SQ_W-1:0]   rad_prev, rad_in;
      norm_side_type     side_prev;
      logic              v_prev;

      if (s == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign side_prev = in_side;
         assign v_prev    = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign rad_prev  = rad_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign v_prev    = v_ff[s-1];
      end

      always_comb begin
         rem_cat = {rem_prev[REM_W-3:0], rad_prev[SQ_W-1 -: 2]};
         trial   = REM_W'({root_prev, 2'b01});
         if (rem_cat >= trial) begin
            rem_in  = rem_cat - trial;
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_cat;
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
         rad_in = rad_prev << 2;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            rad_ff[s]  <= rad_in;
            side_ff[s] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_prev;
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/crdg_div.sv -----
// Three-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
`default_nettype none

module crdg_div
   import crdg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire logic [2:0][NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]       in_den,
   input  wire flags_type              in_flags,
   output logic                        out_valid,
   output logic [2:0][DIR_W-1:0]       out_quot,
   output flags_type                   out_flags
);

   localparam int NS    = DIR_W;
   localparam int REM_W = DEN_W + 1;

   logic [2:0][REM_W-1:0] rem_ff  [NS];
   logic [2:0][NS-1:0]    low_ff  [NS];
   logic [2:0][NS-1:0]    quot_ff [NS];
   logic [DEN_W-1:0]      den_ff  [NS];
   flags_type             flg_ff  [NS];
   logic [NS-1:0]         v_ff;

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic [2:0][REM_W-1:0] rem_prev, rem_in;
      logic [2:0][NS-1:0]    low_prev, low_in, quot_prev, quot_in;
      logic [DEN_W-1:0]      den_prev;
      flags_type             flg_prev;
      logic                  v_prev;

      if (s == 0) begin : g_first
         for (genvar k = 0; k < 3; k++) begin : g_lane
            assign rem_prev[k]  = REM_W'(in_num[k][NUM_W-1:NS]);
            assign low_prev[k]  = in_num[k][NS-1:0];
            assign quot_prev[k] = '0;
         end
         assign den_prev = in_den;
         assign flg_prev = in_flags;
         assign v_prev   = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign low_prev  = low_ff[s-1];
         assign quot_prev = quot_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign flg_prev  = flg_ff[s-1];
         assign v_prev    = v_ff[s-1];
      end

      for (genvar k = 0; k < 3; k++) begin : g_lane_step
         logic [REM_W-1:0] rem_cat;
         always_comb begin
            rem_cat = {rem_prev[k][REM_W-2:0], low_prev[k][NS-1]};
            if (rem_cat >= REM_W'(den_prev)) begin
               rem_in[k]  = rem_cat - REM_W'(den_prev);
               quot_in[k] = {quot_prev[k][NS-2:0], 1'b1};
            end else begin
               rem_in[k]  = rem_cat;
               quot_in[k] = {quot_prev[k][NS-2:0], 1'b0};
            end
            low_in[k] = low_prev[k] << 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            low_ff[s]  <= low_in;
            quot_ff[s] <= quot_in;
            den_ff[s]  <= den_prev;
            flg_ff[s]  <= flg_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_prev;
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_quot  = quot_ff[NS-1];
   assign out_flags = flg_ff[NS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/camera_ray_direction_gen.sv -----
// Throughput: one sample per cycle; the whole pipeline advances together and holds
// only while a finished response waits at the output register.
// The ray length uses a 31-stage square root and a 16-stage divider in pipeline form.
// Reset clears all pipeline valid bits and the three vector registers to zero.
`default_nettype none

module camera_ray_direction_gen
   import crdg_pkg::*;
#(
   parameter int COORD_BITS  = 12,
   parameter int JITTER_BITS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   crdg_req_if.sink    req_chan,
   crdg_rsp_if.source  rsp_chan,
   crdg_csr_if.sink    csr_chan
);

   localparam int T  = COORD_BITS + JITTER_BITS;
   localparam int PW = T + COMP_W + 1;
   localparam int W  = T + COMP_W + 3;
   localparam int MW = W - 1;
   localparam int G  = (MW + 7) / 8;
   localparam int NW = $clog2(MW + 1);
   localparam logic [PIX_W-1:0] PX_MASK =
      (COORD_BITS >= PIX_W) ? '1 : PIX_W'((1 << COORD_BITS) - 1);
   localparam logic [JIT_W-1:0] JT_MASK =
      (JITTER_BITS >= JIT_W) ? '1 : JIT_W'((1 << JITTER_BITS) - 1);
   localparam logic signed [DIR_W-1:0] MAG_FLOOR = 16384;
   localparam logic [DIR_W-1:0] POS_MAX = {1'b0, {(DIR_W-1){1'b1}}};
   localparam logic [DIR_W-1:0] NEG_MAX = {1'b1, {(DIR_W-1){1'b0}}};

   logic [VEC_W-1:0] corner_ff, step_u_ff, step_v_ff;
   logic             advance;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= '0;
         step_u_ff <= '0;
         step_v_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_CORNER_OFFSET: corner_ff <= csr_chan.data;
            CSR_STEP_U:        step_u_ff <= csr_chan.data;
            CSR_STEP_V:        step_v_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   logic rsp_valid_ff;
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // Stage valid bits.
   logic [10:1] v_ff;

   // Stage 1: sample positions in fixed point.
   logic [T-1:0] tu_ff, tv_ff, tu_in, tv_in;
   assign tu_in = (T'(req_chan.pixel_x & PX_MASK) << JITTER_BITS) |
                  T'(req_chan.jitter_u & JT_MASK);
   assign tv_in = (T'(req_chan.pixel_y & PX_MASK) << JITTER_BITS) |
                  T'(req_chan.jitter_v & JT_MASK);

   // Stages 2 to 4: products, sums and sign split.
   logic signed [PW-1:0] pu_ff [3];
   logic signed [PW-1:0] pv_ff [3];
   logic signed [W-1:0]  cw_ff [3];
   logic signed [W-1:0]  p_ff  [3];
   logic [MW-1:0]        mag4_ff [3];
   logic [2:0]           neg4_ff;

   for (genvar k = 0; k < 3; k++) begin : g_comp
      logic signed [COMP_W-1:0] c_k, su_k, sv_k;
      logic signed [PW-1:0]     pu_in, pv_in;
      logic signed [W-1:0]      cw_in, p_in;
      logic [MW-1:0]            mag_in;

      assign c_k   = corner_ff[COMP_W*k +: COMP_W];
      assign su_k  = step_u_ff[COMP_W*k +: COMP_W];
      assign sv_k  = step_v_ff[COMP_W*k +: COMP_W];
      assign pu_in = $signed({1'b0, tu_ff}) * su_k;
      assign pv_in = $signed({1'b0, tv_ff}) * sv_k;
      assign cw_in = {{(W-COMP_W-JITTER_BITS){c_k[COMP_W-1]}}, c_k, {JITTER_BITS{1'b0}}};
      assign p_in  = W'(pu_ff[k]) + W'(pv_ff[k]) + cw_ff[k];
      assign mag_in = p_ff[k][W-1] ? MW'(-p_ff[k]) : MW'(p_ff[k]);

      always_ff @(posedge clock) begin
         if (advance) begin
            pu_ff[k]   <= pu_in;
            pv_ff[k]   <= pv_in;
            cw_ff[k]   <= cw_in;
            p_ff[k]    <= p_in;
            mag4_ff[k] <= mag_in;
            neg4_ff[k] <= p_ff[k][W-1];
         end
      end
   end

   // Stage 5: largest magnitude.
   logic [MW-1:0] mag5_ff [3];
   logic [2:0]    neg5_ff;
   logic [MW-1:0] max_ff, m01, max_in;
   assign m01    = (mag4_ff[0] > mag4_ff[1]) ? mag4_ff[0] : mag4_ff[1];
   assign max_in = (m01 > mag4_ff[2]) ? m01 : mag4_ff[2];

   // Stage 6: per-byte leading one search.
   logic [G*8-1:0] maxp;
   logic [G-1:0]   any_in, any_ff;
   logic [2:0]     pos_in [G];
   logic [2:0]     pos_ff [G];
   logic [MW-1:0]  mag6_ff [3];
   logic [2:0]     neg6_ff;
   assign maxp = (G*8)'(max_ff);

   always_comb begin
      for (int g = 0; g < G; g++) begin
         any_in[g] = |maxp[8*g +: 8];
         pos_in[g] = '0;
         for (int b = 0; b < 8; b++) begin
            if (maxp[8*g+b]) begin
               pos_in[g] = 3'(b);
            end
         end
      end
   end

   // Stage 7: bit length of the largest magnitude.
   logic [NW-1:0] n_in, n_ff;
   logic          degen_in, degen7_ff;
   logic [MW-1:0] mag7_ff [3];
   logic [2:0]    neg7_ff;

   always_comb begin
      n_in = '0;
      for (int g = 0; g < G; g++) begin
         if (any_ff[g]) begin
            n_in = NW'(8 * g) + NW'(pos_ff[g]) + NW'(1);
         end
      end
   end
   assign degen_in = !(|any_ff);

   // Stage 8: normalised magnitudes, stage 9: squares, stage 10: sum of squares.
   logic [2:0][NORM_BITS-1:0] a8_ff, a9_ff, a10_ff, a_in;
   logic [2*NORM_BITS-1:0]    sq_ff [3];
   logic [SQ_W-1:0]           sum_ff, sum_in;
   flags_type                 fl8_ff, fl9_ff, fl10_ff;

   for (genvar k = 0; k < 3; k++) begin : g_norm
      logic [MW+NORM_BITS-1:0] ext;
      assign ext     = {mag7_ff[k], {NORM_BITS{1'b0}}};
      assign a_in[k] = NORM_BITS'(ext >> n_ff);
   end
   assign sum_in = SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (advance) begin
         tu_ff     <= tu_in;
         tv_ff     <= tv_in;
         mag5_ff   <= mag4_ff;
         neg5_ff   <= neg4_ff;
         max_ff    <= max_in;
         any_ff    <= any_in;
         pos_ff    <= pos_in;
         mag6_ff   <= mag5_ff;
         neg6_ff   <= neg5_ff;
         n_ff      <= n_in;
         degen7_ff <= degen_in;
         mag7_ff   <= mag6_ff;
         neg7_ff   <= neg6_ff;
         a8_ff     <= a_in;
         fl8_ff    <= '{neg: neg7_ff, degen: degen7_ff};
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= a8_ff[k] * a8_ff[k];
         end
         a9_ff     <= a8_ff;
         fl9_ff    <= fl8_ff;
         sum_ff    <= sum_in;
         a10_ff    <= a9_ff;
         fl10_ff   <= fl9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[9:1], req_chan.valid};
      end
   end

   // Length by square root.
   logic              sq_valid;
   logic [ROOT_W-1:0] root;
   norm_side_type     sq_side;
   norm_side_type     sq_in_side;

   assign sq_in_side = '{a: a10_ff, flags: fl10_ff};

   crdg_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (v_ff[10]),
      .in_rad    (sum_ff),
      .in_side   (sq_in_side),
      .out_valid (sq_valid),
      .out_root  (root),
      .out_side  (sq_side)
   );

   // Divider operands: a * 2^16 + L over 2 * L.
   logic [2:0][NUM_W-1:0] num_ff;
   logic [DEN_W-1:0]      den_ff;
   flags_type             fld_ff;
   logic                  vd_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= NUM_W'({sq_side.a[k], {DIR_W{1'b0}}}) + NUM_W'(root);
         end
         den_ff <= {root, 1'b0};
         fld_ff <= sq_side.flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (advance) begin
         vd_ff <= sq_valid;
      end
   end

   logic                  dv_valid;
   logic [2:0][DIR_W-1:0] quot;
   flags_type             dv_flags;

   crdg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (vd_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_flags  (fld_ff),
      .out_valid (dv_valid),
      .out_quot  (quot),
      .out_flags (dv_flags)
   );

   // Output register: sign, saturation and the zero-length case.
   logic [2:0][DIR_W-1:0] dir_in, dir_ff;
   logic                  degen_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dv_flags.degen) begin
            dir_in[k] = '0;
         end else if (dv_flags.neg[k]) begin
            dir_in[k] = (quot[k] > NEG_MAX) ? NEG_MAX : DIR_W'(-quot[k]);
         end else begin
            dir_in[k] = (quot[k] > POS_MAX) ? POS_MAX : quot[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dir_ff   <= dir_in;
         degen_ff <= dv_flags.degen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.dir_x      = dir_ff[0];
   assign rsp_chan.dir_y      = dir_ff[1];
   assign rsp_chan.dir_z      = dir_ff[2];
   assign rsp_chan.degenerate = degen_ff;

   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.degenerate) |->
      (rsp_chan.dir_x == '0 && rsp_chan.dir_y == '0 && rsp_chan.dir_z == '0))
      else $error("degenerate response with non-zero direction");

   a_unit_len : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.degenerate) |->
      (rsp_chan.dir_x >= MAG_FLOOR || rsp_chan.dir_x <= -MAG_FLOOR ||
       rsp_chan.dir_y >= MAG_FLOOR || rsp_chan.dir_y <= -MAG_FLOOR ||
       rsp_chan.dir_z >= MAG_FLOOR || rsp_chan.dir_z <= -MAG_FLOOR))
      else $error("direction far from unit length");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while the pipeline is stalled");

endmodule

`default_nettype wire

// ----- dv/tb_camera_ray_direction_gen.sv -----
// Self-checking testbench for camera_ray_direction_gen: random traffic with a built-in ray predictor.
`default_nettype none

module tb_camera_ray_direction_gen;
   import crdg_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] py;
      logic [JIT_W-1:0] ju;
      logic [JIT_W-1:0] jv;
   } sample_type;

   typedef struct {
      logic signed [DIR_W-1:0] dx;
      logic signed [DIR_W-1:0] dy;
      logic signed [DIR_W-1:0] dz;
      logic                    degen;
   } ray_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   crdg_req_if req_if ();
   crdg_rsp_if rsp_if ();
   crdg_csr_if csr_if ();

   camera_ray_direction_gen DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #5 clock = ~clock;

   logic [VEC_W-1:0] corner_vec = '0;
   logic [VEC_W-1:0] step_u_vec = '0;
   logic [VEC_W-1:0] step_v_vec = '0;

   sample_type pending_samples[$];
   ray_type    expected_rays[$];
   int      error_count = 0;
   int      rays_checked = 0;
   int      degenerate_seen = 0;
   int      saturated_seen = 0;
   int      csr_writes = 0;
   int      cycle_count = 0;
   int      gap_left = 0;
   int      burst_left = 1;
   int      stall_mode = 0;
   int      stall_timer = 0;

   function automatic longint comp_of(logic [VEC_W-1:0] v, int k);
      logic signed [COMP_W-1:0] c;
      c = v[COMP_W*k +: COMP_W];
      return longint'(c);
   endfunction

   function automatic longint unsigned root_of(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic ray_type predict_ray(sample_type s);
      ray_type r;
      longint tu, tv, p;
      longint unsigned mag[3];
      bit neg[3];
      longint unsigned maxm, sum, len, q;
      logic [DIR_W-1:0] d[3];
      int n;
      tu = longint'({s.px, s.ju});
      tv = longint'({s.py, s.jv});
      maxm = 0;
      for (int k = 0; k < 3; k++) begin
         p = comp_of(corner_vec, k) * 65536 + tu * comp_of(step_u_vec, k)
             + tv * comp_of(step_v_vec, k);
         neg[k] = p < 0;
         mag[k] = neg[k] ? longint'(-p) : p;
         if (mag[k] > maxm) maxm = mag[k];
      end
      if (maxm == 0) begin
         r.dx = '0;
         r.dy = '0;
         r.dz = '0;
         r.degen = 1'b1;
         return r;
      end
      n = 0;
      while ((maxm >> n) != 0) n++;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
         if (n > NORM_BITS) mag[k] = mag[k] >> (n - NORM_BITS);
         else mag[k] = mag[k] << (NORM_BITS - n);
         sum += mag[k] * mag[k];
      end
      len = root_of(sum);
      for (int k = 0; k < 3; k++) begin
         q = ((mag[k] << 16) + len) / (2 * len);
         if (neg[k]) begin
            if (q > 32768) q = 32768;
            d[k] = DIR_W'(-q);
         end else begin
            if (q > 32767) q = 32767;
            d[k] = DIR_W'(q);
         end
      end
      r.dx = d[0];
      r.dy = d[1];
      r.dz = d[2];
      r.degen = 1'b0;
      return r;
   endfunction

   // Request driver: bursts of transfers separated by random gaps.
   always @(posedge clock) begin
      sample_type s;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left > 0 || pending_samples.size() == 0) begin
            req_if.valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end else begin
            s = pending_samples.pop_front();
            req_if.pixel_x  <= s.px;
            req_if.pixel_y  <= s.py;
            req_if.jitter_u <= s.ju;
            req_if.jitter_v <= s.jv;
            req_if.valid    <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // Response sink stalls in modes that change every so often.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (stall_timer == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_timer = $urandom_range(16, 96);
         end else begin
            stall_timer--;
         end
         case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 1) == 0);
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Monitor: predict on each request transfer, check on each response transfer.
   always @(posedge clock) begin
      sample_type s;
      ray_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            s.px = req_if.pixel_x;
            s.py = req_if.pixel_y;
            s.ju = req_if.jitter_u;
            s.jv = req_if.jitter_v;
            expected_rays.push_back(predict_ray(s));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rays.size() == 0) begin
               $error("response transfer with no ray expected");
               error_count++;
            end else begin
               want = expected_rays.pop_front();
               rays_checked++;
               if (want.degen) degenerate_seen++;
               if (want.dx == 16'sh7fff || want.dx == -16'sh8000) saturated_seen++;
               if (rsp_if.dir_x !== want.dx) begin
                  $error("dir_x expected %0d actual %0d", want.dx, rsp_if.dir_x);
                  error_count++;
               end
               if (rsp_if.dir_y !== want.dy) begin
                  $error("dir_y expected %0d actual %0d", want.dy, rsp_if.dir_y);
                  error_count++;
               end
               if (rsp_if.dir_z !== want.dz) begin
                  $error("dir_z expected %0d actual %0d", want.dz, rsp_if.dir_z);
                  error_count++;
               end
               if (rsp_if.degenerate !== want.degen) begin
                  $error("degenerate expected %0b actual %0b", want.degen, rsp_if.degenerate);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [VEC_W-1:0] value);
      @(posedge clock);
      csr_if.index <= idx;
      csr_if.data  <= value;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_CORNER_OFFSET: corner_vec = value;
         CSR_STEP_U:        step_u_vec = value;
         CSR_STEP_V:        step_v_vec = value;
         default: ;
      endcase
      csr_writes++;
      csr_if.valid <= 1'b0;
   endtask

   task automatic add_sample(int px, int py, int ju, int jv);
      sample_type s;
      s.px = px;
      s.py = py;
      s.ju = ju;
      s.jv = jv;
      pending_samples.push_back(s);
   endtask

   task automatic add_random(int count);
      int px, py;
      for (int i = 0; i < count; i++) begin
         px = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 255);
         py = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 255);
         add_sample(px, py, $urandom_range(0, 65535), $urandom_range(0, 65535));
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_if.valid || expected_rays.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [VEC_W-1:0] rand_vec(int mode);
      logic [COMP_W-1:0] c[3];
      for (int k = 0; k < 3; k++) begin
         case (mode)
            0: c[k] = COMP_W'($urandom);
            1: c[k] = COMP_W'($urandom_range(0, 511)) - COMP_W'(256);
            default: c[k] = ($urandom_range(0, 2) == 0) ? '0 : COMP_W'($urandom);
         endcase
      end
      return {c[2], c[1], c[0]};
   endfunction

   initial begin
      req_if.valid = 1'b0;
      req_if.pixel_x = '0;
      req_if.pixel_y = '0;
      req_if.jitter_u = '0;
      req_if.jitter_v = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Registers at reset value: every sample is a zero vector.
      add_sample(0, 0, 0, 0);
      add_sample(4095, 4095, 65535, 65535);
      add_sample(4095, 0, 0, 65535);
      wait_idle();

      // Axis-aligned corner: the positive and negative unit results saturate.
      write_reg(CSR_CORNER_OFFSET, 60'h00000_00000_7ffff);
      write_reg(CSR_STEP_U, '0);
      write_reg(CSR_STEP_V, '0);
      add_sample(0, 0, 0, 0);
      add_sample(4095, 4095, 65535, 65535);
      wait_idle();
      write_reg(CSR_CORNER_OFFSET, 60'h00000_80000_00000);
      add_sample(17, 3, 1, 32768);
      wait_idle();
      write_reg(CSR_CORNER_OFFSET, 60'h80000_00000_00000);
      add_sample(5, 9, 0, 0);
      wait_idle();

      // Extreme vectors in every register.
      write_reg(CSR_CORNER_OFFSET, {3{20'h7ffff}});
      write_reg(CSR_STEP_U, {3{20'h7ffff}});
      write_reg(CSR_STEP_V, {3{20'h7ffff}});
      write_reg(CSR_UNUSED, {3{20'h12345}});
      add_sample(0, 0, 0, 0);
      add_sample(4095, 4095, 65535, 65535);
      add_sample(4095, 0, 65535, 0);
      add_sample(0, 4095, 0, 65535);
      wait_idle();
      write_reg(CSR_CORNER_OFFSET, {3{20'h80000}});
      write_reg(CSR_STEP_U, {3{20'h80000}});
      write_reg(CSR_STEP_V, {20'h7ffff, 20'h80000, 20'h00001});
      add_sample(0, 0, 0, 0);
      add_sample(4095, 4095, 65535, 65535);
      add_sample(2048, 1, 1, 65534);
      add_sample(1, 2048, 65534, 1);
      wait_idle();

      // Cancelling case: corner and steps sum to zero at one sample.
      write_reg(CSR_CORNER_OFFSET, {20'h00000, 20'h00000, 20'hffffe});
      write_reg(CSR_STEP_U, {20'h00000, 20'h00000, 20'h00001});
      write_reg(CSR_STEP_V, '0);
      add_sample(2, 7, 0, 1234);
      add_sample(1, 7, 65535, 1234);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         write_reg(CSR_CORNER_OFFSET, rand_vec(phase % 3));
         write_reg(CSR_STEP_U, rand_vec((phase + 1) % 3));
         write_reg(CSR_STEP_V, rand_vec((phase + 2) % 3));
         add_random(215);
         wait_idle();
      end

      $display("Checked %0d rays over %0d register writes; %0d degenerate, %0d saturated x.",
               rays_checked, csr_writes, degenerate_seen, saturated_seen);
      if (error_count == 0 && expected_rays.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
